>>> rtl/mode_margin_frequency_filter_core_defines.svh
// assertion macros for the mode-margin frequency filter
`ifndef MODE_MARGIN_FREQUENCY_FILTER_CORE_DEFINES_SVH
`define MODE_MARGIN_FREQUENCY_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define MMFF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mmff assertion failed");
// checked during reset too
`define MMFF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mmff assertion failed");
`else
`define MMFF_ASSERT(label, prop)
`define MMFF_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/mmff_pkg.sv
package mmff_pkg;

  localparam int TableDepth  = 256;
  localparam int ValueWidth  = 32;
  localparam int ItemWidth   = 32;
  localparam int CountWidth  = 9;
  localparam int MarginWidth = 9;
  localparam int KeptWidth   = 16;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [KeptWidth-1:0]  KeptMax  = {KeptWidth{1'b1}};

  // request codes
  localparam logic [1:0] ReqClear = 2'd0;
  localparam logic [1:0] ReqLoad  = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  typedef logic [ValueWidth-1:0] key_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic [1:0]            req;
    logic [ItemWidth-1:0]  item;
    key_t                  key;
    logic                  last;
    logic                  found;
    logic [CountWidth-1:0] cnt;
  } tok_t;

  // one result beat
  typedef struct packed {
    logic [KeptWidth-1:0] kept;
    logic [ItemWidth-1:0] value;
    logic                 keep;
    logic                 last;
    logic                 ovf;
  } res_t;

  // sign-extend the item, then keep the compare width
  function automatic key_t to_key(input logic [ItemWidth-1:0] item);
    logic signed [ItemWidth+ValueWidth-1:0] ext;
    ext = (ItemWidth+ValueWidth)'($signed(item));
    return ext[ValueWidth-1:0];
  endfunction

endpackage

>>> rtl/mode_margin_frequency_filter_core.sv
// mode-margin frequency filter: a row of TableDepth cells, one table entry each, holds the
// reference values and their counts. every accepted beat enters the row and, unless it is
// stalled, moves one cell per cycle: a load bumps the count in the matching cell or claims
// the first free cell, a query picks up the count of its matching cell, a clear frees each
// cell as it passes. a tail stage keeps the mode count, the sticky overflow flag and the
// batch keep count and registers the result. a query's result passes the TableDepth cell
// registers, then the output register. one beat enters per cycle unless the input stalls
// (only while a query sits at the end of the row and the output register is full and not
// taken). loads and clears give no output beat, type 3 is ignored. the user must write
// keep_margin on the cfg channel only while no beat is in flight; the block does not
// enforce it. it resets to 1. reset frees all cells at once, so no clearing pass follows.
`include "mode_margin_frequency_filter_core_defines.svh"

module mode_margin_frequency_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,      // keep_margin
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // item_value
  input  logic [1:0]  s_axis_tuser,    // req_type
  input  logic        s_axis_tlast,    // last_item
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // out_value [31:0], kept_so_far [47:32]
  output logic [1:0]  m_axis_tuser,    // keep_flag [0], overflowed [1]
  output logic        m_axis_tlast     // out_last
);
  import mmff_pkg::*;

  logic [MarginWidth-1:0] margin_q;
  logic                   adv;
  tok_t                   chain [TableDepth+1];
  tok_t                   tail_tok;
  res_t                   res;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginWidth'(1);
    end else if (cfg_valid_i) begin
      margin_q <= cfg_data_i;
    end
  end

  // head token built from the input beat
  assign s_axis_tready = adv;

  always_comb begin
    chain[0].vld   = s_axis_tvalid && adv;
    chain[0].req   = s_axis_tuser;
    chain[0].item  = s_axis_tdata;
    chain[0].key   = to_key(s_axis_tdata);
    chain[0].last  = s_axis_tlast;
    chain[0].found = 1'b0;
    chain[0].cnt   = '0;
  end

  // row of table cells
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    mmff_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  assign tail_tok = chain[TableDepth];

  // mode count, overflow, batch count and output register
  mmff_tail u_tail (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tok_i    (tail_tok),
    .margin_i (margin_q),
    .ready_i  (m_axis_tready),
    .adv_o    (adv),
    .valid_o  (m_axis_tvalid),
    .res_o    (res)
  );

  assign m_axis_tdata = {res.kept, res.value};
  assign m_axis_tuser = {res.ovf, res.keep};
  assign m_axis_tlast = res.last;

  // input only stalls behind an untaken result
  `MMFF_ASSERT_ALWAYS(a_stall_cause, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
  // a stall always has a query at the end of the row
  `MMFF_ASSERT(a_stall_query, !adv |-> (tail_tok.vld && tail_tok.req == ReqQuery))
  // a kept query counts itself
  `MMFF_ASSERT(a_kept_count, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[47:32] != '0))

endmodule

>>> rtl/mmff_cell.sv
module mmff_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  mmff_pkg::tok_t tok_i,
  output mmff_pkg::tok_t tok_o
);
  import mmff_pkg::*;

  logic                  used_q, used_d;
  key_t                  val_q, val_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  tok_t                  tok_q, tok_d;
  logic                  hit;

  assign hit = used_q && (val_q == tok_i.key);

  always_comb begin
    used_d = used_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    tok_d  = tok_i;
    if (tok_i.vld) begin
      case (tok_i.req)
        ReqClear: begin
          used_d = 1'b0;
        end
        ReqLoad: begin
          if (!tok_i.found) begin
            if (hit) begin
              cnt_d       = (cnt_q == CountMax) ? cnt_q : cnt_q + CountWidth'(1);
              tok_d.found = 1'b1;
              tok_d.cnt   = cnt_d;
            end else if (!used_q) begin
              // first free cell takes the new value
              used_d      = 1'b1;
              val_d       = tok_i.key;
              cnt_d       = CountWidth'(1);
              tok_d.found = 1'b1;
              tok_d.cnt   = CountWidth'(1);
            end
          end
        end
        ReqQuery: begin
          if (!tok_i.found && hit) begin
            tok_d.found = 1'b1;
            tok_d.cnt   = cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else if (adv_i) begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q <= val_d;
      cnt_q <= cnt_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/mmff_tail.sv
module mmff_tail (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mmff_pkg::tok_t                  tok_i,
  input  logic [mmff_pkg::MarginWidth-1:0] margin_i,
  input  logic                            ready_i,
  output logic                            adv_o,
  output logic                            valid_o,
  output mmff_pkg::res_t                  res_o
);
  import mmff_pkg::*;

  logic [CountWidth-1:0] mode_q, mode_d;
  logic [KeptWidth-1:0]  batch_q, batch_d, kept_inc;
  logic                  ovf_q, ovf_d;
  logic                  out_vld_q, out_vld_d;
  res_t                  res_q;
  logic                  is_res, keep;
  logic [CountWidth-1:0] cnt;
  logic [CountWidth:0]   reach;

  assign is_res = tok_i.vld && (tok_i.req == ReqQuery);
  // only a query waiting on a full output register that is not taken holds the chain
  assign adv_o  = !(is_res && out_vld_q && !ready_i);

  assign cnt      = tok_i.found ? tok_i.cnt : '0;
  assign reach    = {1'b0, cnt} + (CountWidth+1)'(margin_i);
  assign keep     = reach >= {1'b0, mode_q};
  assign kept_inc = (keep && batch_q != KeptMax) ? batch_q + KeptWidth'(1) : batch_q;

  always_comb begin
    mode_d    = mode_q;
    batch_d   = batch_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q;
    if (ready_i) begin
      out_vld_d = 1'b0;
    end
    if (adv_o && tok_i.vld) begin
      case (tok_i.req)
        ReqClear: begin
          mode_d = '0;
        end
        ReqLoad: begin
          if (!tok_i.found) begin
            ovf_d = 1'b1;
          end else if (tok_i.cnt > mode_q) begin
            mode_d = tok_i.cnt;
          end
        end
        ReqQuery: begin
          batch_d   = tok_i.last ? '0 : kept_inc;
          out_vld_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      batch_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      batch_q   <= batch_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && is_res) begin
      res_q.value <= tok_i.item;
      res_q.keep  <= keep;
      res_q.kept  <= kept_inc;
      res_q.last  <= tok_i.last;
      res_q.ovf   <= ovf_q;
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

endmodule
